// ===== hdl/mstk_pkg.sv =====
// ----------------------------------------------------------------------------
// mstk_pkg
// Shared constants and types of the Kruskal spanning tree unit.
// ----------------------------------------------------------------------------
package mstk_pkg;

  localparam int unsigned MaxNodes  = 64;
  localparam int unsigned MaxEdges  = 256;
  localparam int unsigned NodeW     = 6;
  localparam int unsigned CostW     = 16;
  localparam int unsigned CountW    = 7;
  localparam int unsigned RankW     = 3;
  localparam logic [CountW-1:0] NodeCountReset = 7'd64;

  // one queued edge from front to back
  typedef struct packed {
    logic             keep;
    logic             last;
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;
    logic [CostW-1:0] cost;
  } edge_cmd_t;

endpackage

// ===== hdl/mstk_ram.sv =====
// ----------------------------------------------------------------------------
// mstk_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mstk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/mstk_front.sv =====
// ----------------------------------------------------------------------------
// mstk_front
// Accepts edges, range checks them against node_count and queues them.
// ----------------------------------------------------------------------------
module mstk_front #(
  parameter int unsigned MaxNodes = mstk_pkg::MaxNodes
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            take_i,
  input  logic [mstk_pkg::NodeW-1:0]      src_i,
  input  logic [mstk_pkg::NodeW-1:0]      dst_i,
  input  logic [mstk_pkg::CostW-1:0]      cost_i,
  input  logic                            last_i,
  input  logic                            cfg_we_i,
  input  logic [mstk_pkg::CountW-1:0]     cfg_data_i,
  output logic                            q_valid_o,
  output mstk_pkg::edge_cmd_t             q_data_o,
  input  logic                            q_pop_i
);

  logic [mstk_pkg::CountW-1:0] node_count_q;
  logic [mstk_pkg::CountW-1:0] limit;
  logic                        in_range;
  // two-entry queue
  mstk_pkg::edge_cmd_t         slot_q [2];
  logic                        rd_q, wr_q;
  logic [1:0]                  cnt_q;
  mstk_pkg::edge_cmd_t         cmd;

  assign limit = (node_count_q < mstk_pkg::CountW'(MaxNodes)) ? node_count_q
                                                             : mstk_pkg::CountW'(MaxNodes);
  assign in_range = ({1'b0, src_i} < limit) && ({1'b0, dst_i} < limit);

  always_comb begin
    cmd.keep = in_range;
    cmd.last = last_i;
    cmd.src  = src_i;
    cmd.dst  = dst_i;
    cmd.cost = cost_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= mstk_pkg::NodeCountReset;
      rd_q         <= 1'b0;
      wr_q         <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_data_i;
      end
      if (take_i) begin
        wr_q <= ~wr_q;
      end
      if (q_pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(take_i) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      slot_q[wr_q] <= cmd;
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = slot_q[rd_q];

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overfill");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == 2'd2) |-> !take_i)
    else $error("push into full queue");

endmodule

// ===== hdl/mstk_back.sv =====
// ----------------------------------------------------------------------------
// mstk_back
// Stores edges, sorts them stably, then runs union-find and emits tree edges.
// ----------------------------------------------------------------------------
module mstk_back #(
  parameter int unsigned MaxNodes = mstk_pkg::MaxNodes,
  parameter int unsigned MaxEdges = mstk_pkg::MaxEdges
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  mstk_pkg::edge_cmd_t         q_data_i,
  output logic                        q_pop_o,
  output logic                        idle_o,
  output logic                        res_stb_o,
  output logic                        res_edge_o,
  output logic [mstk_pkg::NodeW-1:0]  res_src_o,
  output logic [mstk_pkg::NodeW-1:0]  res_dst_o,
  output logic [mstk_pkg::CostW-1:0]  res_cost_o,
  output logic                        res_last_o,
  output logic                        res_drop_o
);

  localparam int unsigned AW = $clog2(MaxEdges);
  localparam int unsigned FW = AW + 1;
  localparam int unsigned NW = $clog2(MaxNodes);
  localparam int unsigned EW = 2 * mstk_pkg::NodeW + mstk_pkg::CostW;
  localparam int unsigned RW = mstk_pkg::RankW;

  typedef enum logic [4:0] {
    S_LOAD, S_OUTER, S_WAITJ, S_RDJ, S_CMPJ, S_WRKEY,
    S_INIT, S_RDE, S_WAITE, S_FIND, S_CLIMB, S_COMP, S_RKB, S_UNION, S_END
  } state_e;

  state_e state_q;

  // edge store: one RAM, read and written by the insertion sort in place
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  mstk_ram #(.Width(EW), .Depth(MaxEdges)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // union-find store: parent and rank RAMs, cleared by a pass before each scan
  logic          p_we;
  logic [NW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  logic          r_we;
  logic [NW-1:0] r_waddr, r_raddr;
  logic [RW-1:0] r_wdata, r_rdata;

  mstk_ram #(.Width(NW), .Depth(MaxNodes)) u_parent (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  mstk_ram #(.Width(RW), .Depth(MaxNodes)) u_rank (
    .clk_i, .we_i(r_we), .waddr_i(r_waddr), .wdata_i(r_wdata),
    .raddr_i(r_raddr), .rdata_o(r_rdata)
  );

  logic [FW-1:0] fill_q, i_q, j_q;
  logic          drop_q;
  logic [EW-1:0] key_q, cur_q;
  logic [NW-1:0] node_q, ra_q, walk_q, clr_q;
  logic          side_q;  // find: 0 for the source end, 1 for the destination
  logic [RW-1:0] rka_q;
  logic [NW:0]   emit_q;
  logic          out_stb_q, out_edge_q, out_last_q, out_drop_q;
  logic [EW-1:0] out_e_q;

  logic [mstk_pkg::CostW-1:0] key_cost, rd_cost;
  logic [NW-1:0] a_n, b_n;
  assign key_cost = key_q[mstk_pkg::CostW-1:0];
  assign rd_cost  = rdata[mstk_pkg::CostW-1:0];
  assign a_n = NW'(cur_q[EW-1 -: mstk_pkg::NodeW]);
  assign b_n = NW'(cur_q[EW-1-mstk_pkg::NodeW -: mstk_pkg::NodeW]);

  assign q_pop_o = (state_q == S_LOAD) && q_valid_i;
  assign idle_o  = (state_q == S_LOAD) && !q_valid_i;

  always_comb begin
    we      = 1'b0;
    waddr   = fill_q[AW-1:0];
    wdata   = {q_data_i.src, q_data_i.dst, q_data_i.cost};
    raddr   = i_q[AW-1:0];
    p_we    = 1'b0;
    p_waddr = walk_q;
    p_wdata = node_q;
    p_raddr = node_q;
    r_we    = 1'b0;
    r_waddr = ra_q;
    r_wdata = '0;
    r_raddr = ra_q;
    unique case (state_q)
      S_LOAD: we = q_pop_o && q_data_i.keep && (fill_q != FW'(MaxEdges));
      S_RDJ:  raddr = AW'(j_q - FW'(1));
      S_CMPJ: begin
        we    = (rd_cost > key_cost);
        waddr = j_q[AW-1:0];
        wdata = rdata;
      end
      S_WRKEY: begin
        we    = 1'b1;
        waddr = j_q[AW-1:0];
        wdata = key_q;
      end
      S_INIT: begin
        p_we    = 1'b1;
        p_waddr = clr_q;
        p_wdata = clr_q;
        r_we    = 1'b1;
        r_waddr = clr_q;
      end
      S_FIND:  p_raddr = a_n;
      // follow the parent chain, or start the compress walk at the first path node
      S_CLIMB: p_raddr = (p_rdata != node_q) ? p_rdata : walk_q;
      S_COMP: begin
        if (walk_q != node_q) begin
          p_we    = 1'b1;
          p_raddr = p_rdata;
        end else if (!side_q) begin
          p_raddr = b_n;
        end
      end
      S_RKB: r_raddr = node_q;
      S_UNION: begin
        if (ra_q != node_q) begin
          p_we = 1'b1;
          if (rka_q < r_rdata) begin
            p_waddr = ra_q;
            p_wdata = node_q;
          end else begin
            p_waddr = node_q;
            p_wdata = ra_q;
            r_we    = (rka_q == r_rdata);
            r_wdata = rka_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      fill_q     <= '0;
      drop_q     <= 1'b0;
      out_stb_q  <= 1'b0;
      out_edge_q <= 1'b0;
      out_last_q <= 1'b0;
      out_drop_q <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      emit_q     <= '0;
      side_q     <= 1'b0;
      clr_q      <= '0;
    end else begin
      out_stb_q <= 1'b0;
      unique case (state_q)
        S_LOAD: if (q_pop_o) begin
          if (we) begin
            fill_q <= fill_q + FW'(1);
          end else begin
            drop_q <= 1'b1;
          end
          if (q_data_i.last) begin
            i_q     <= FW'(1);
            state_q <= S_OUTER;
          end
        end
        S_OUTER: begin
          if (i_q >= fill_q) begin
            state_q <= S_INIT;
          end else begin
            state_q <= S_WAITJ;
          end
          j_q <= i_q;
        end
        S_WAITJ: begin
          key_q   <= rdata;
          state_q <= (j_q == '0) ? S_WRKEY : S_RDJ;
        end
        S_RDJ: state_q <= S_CMPJ;
        S_CMPJ: begin
          if (rd_cost > key_cost) begin
            j_q     <= j_q - FW'(1);
            state_q <= (j_q == FW'(1)) ? S_WRKEY : S_RDJ;
          end else begin
            state_q <= S_WRKEY;
          end
        end
        S_WRKEY: begin
          i_q     <= i_q + FW'(1);
          state_q <= S_OUTER;
        end
        // one parent and rank entry cleared per cycle
        S_INIT: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == NW'(MaxNodes - 1)) begin
            clr_q   <= '0;
            i_q     <= '0;
            emit_q  <= '0;
            state_q <= S_RDE;
          end
        end
        S_RDE: begin
          if (i_q >= fill_q || emit_q == (NW+1)'(MaxNodes - 1)) begin
            state_q <= S_END;
          end else begin
            state_q <= S_WAITE;
          end
        end
        S_WAITE: begin
          cur_q   <= rdata;
          i_q     <= i_q + FW'(1);
          state_q <= S_FIND;
        end
        S_FIND: begin
          node_q  <= a_n;
          walk_q  <= a_n;
          side_q  <= 1'b0;
          state_q <= S_CLIMB;
        end
        // climb one level per cycle until a node is its own parent
        S_CLIMB: begin
          if (p_rdata != node_q) begin
            node_q <= p_rdata;
          end else begin
            state_q <= S_COMP;
          end
        end
        // point each node on the path at the root, one per cycle
        S_COMP: begin
          if (walk_q != node_q) begin
            walk_q <= p_rdata;
          end else if (!side_q) begin
            ra_q    <= node_q;
            node_q  <= b_n;
            walk_q  <= b_n;
            side_q  <= 1'b1;
            state_q <= S_CLIMB;
          end else begin
            state_q <= S_RKB;
          end
        end
        S_RKB: begin
          rka_q   <= r_rdata;
          state_q <= S_UNION;
        end
        S_UNION: begin
          if (ra_q != node_q) begin
            out_stb_q  <= 1'b1;
            out_edge_q <= 1'b1;
            out_last_q <= 1'b0;
            out_drop_q <= 1'b0;
            out_e_q    <= cur_q;
            emit_q     <= emit_q + 1'b1;
          end
          state_q <= S_RDE;
        end
        S_END: begin
          out_stb_q  <= 1'b1;
          out_edge_q <= 1'b0;
          out_last_q <= 1'b1;
          out_drop_q <= drop_q;
          out_e_q    <= '0;
          fill_q     <= '0;
          drop_q     <= 1'b0;
          state_q    <= S_LOAD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign res_stb_o  = out_stb_q;
  assign res_edge_o = out_edge_q;
  assign res_src_o  = out_e_q[EW-1 -: mstk_pkg::NodeW];
  assign res_dst_o  = out_e_q[EW-1-mstk_pkg::NodeW -: mstk_pkg::NodeW];
  assign res_cost_o = out_e_q[mstk_pkg::CostW-1:0];
  assign res_last_o = out_last_q;
  assign res_drop_o = out_drop_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FW'(MaxEdges))
    else $error("fill beyond store");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_stb_q |-> (out_edge_q != out_last_q))
    else $error("result is both edge and marker");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   emit_q <= (NW+1)'(MaxNodes - 1))
    else $error("too many tree edges");

endmodule

// ===== hdl/minimum_spanning_tree_kruskal_unit.sv =====
// ----------------------------------------------------------------------------
// minimum_spanning_tree_kruskal_unit
// Kruskal minimum spanning forest over streamed weighted edges.
// ----------------------------------------------------------------------------
// Edges are taken one per cycle while loading; busy stays low until the item
// marked last is taken. The edge store RAM, which has a single read port, is
// then insertion sorted in place. A clearing pass over all MaxNodes entries
// resets the union-find RAMs; then each sorted edge is read, both of its ends
// are found by climbing to their roots, the paths are re-pointed at the roots
// by compression, and the two roots are joined by rank.
// Results appear on result_valid_o for one cycle each and cannot be held off,
// ending with an end marker; busy stays high until that marker is out.
module minimum_spanning_tree_kruskal_unit #(
  parameter int unsigned MaxNodes = mstk_pkg::MaxNodes,
  parameter int unsigned MaxEdges = mstk_pkg::MaxEdges
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [mstk_pkg::NodeW-1:0]     edge_src_i,
  input  logic [mstk_pkg::NodeW-1:0]     edge_dst_i,
  input  logic [mstk_pkg::CostW-1:0]     edge_cost_i,
  input  logic                           edge_is_last_i,
  input  logic                           cfg_we_i,
  input  logic [mstk_pkg::CountW-1:0]    cfg_wdata_i,
  output logic                           result_valid_o,
  output logic                           out_valid_edge_o,
  output logic [mstk_pkg::NodeW-1:0]     out_src_o,
  output logic [mstk_pkg::NodeW-1:0]     out_dst_o,
  output logic [mstk_pkg::CostW-1:0]     out_cost_o,
  output logic                           out_last_o,
  output logic                           out_dropped_o
);

  logic                q_valid, q_pop, back_idle, take;
  mstk_pkg::edge_cmd_t q_data;
  logic                run_q;  // a last edge has entered and is not done

  assign busy = run_q || (q_valid && !q_pop);
  assign take = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (take && edge_is_last_i) begin
      run_q <= 1'b1;
    end else if (result_valid_o && out_last_o) begin
      run_q <= 1'b0;
    end
  end

  mstk_front #(.MaxNodes(MaxNodes)) u_front (
    .clk_i, .rst_ni, .take_i(take),
    .src_i(edge_src_i), .dst_i(edge_dst_i), .cost_i(edge_cost_i),
    .last_i(edge_is_last_i), .cfg_we_i, .cfg_data_i(cfg_wdata_i),
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  mstk_back #(.MaxNodes(MaxNodes), .MaxEdges(MaxEdges)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .idle_o(back_idle), .res_stb_o(result_valid_o), .res_edge_o(out_valid_edge_o),
    .res_src_o(out_src_o), .res_dst_o(out_dst_o), .res_cost_o(out_cost_o),
    .res_last_o(out_last_o), .res_drop_o(out_dropped_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   run_q |-> !take)
    else $error("edge taken during computation");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (result_valid_o && out_last_o) |=> !run_q)
    else $error("busy after end marker");
  // the end marker leaves with the back end already back at loading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (result_valid_o && !out_last_o) |-> !back_idle)
    else $error("result while back end idle");

endmodule

// ===== tb/sv/minimum_spanning_tree_kruskal_unit_test.sv =====
// ----------------------------------------------------------------------------
// minimum_spanning_tree_kruskal_unit_test
// Streams random graphs into the Kruskal unit. A scoreboard predicts
// the tree edges and end marker of each graph and checks every result field.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_kruskal_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NodeW    = mstk_pkg::NodeW;
  localparam int unsigned CostW    = mstk_pkg::CostW;
  localparam int unsigned CountW   = mstk_pkg::CountW;
  localparam int unsigned RankW    = mstk_pkg::RankW;
  localparam int unsigned MaxNodes = mstk_pkg::MaxNodes;
  localparam int unsigned MaxEdges = mstk_pkg::MaxEdges;
  localparam logic [CountW-1:0] NodeCountReset = mstk_pkg::NodeCountReset;

  localparam int unsigned DrainCycles = 200;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned ItemTarget = 270;
  localparam int unsigned BigGraph = MaxEdges + 2;  // overflows a full store

  typedef struct {
    bit             is_edge;
    bit [NodeW-1:0] src;
    bit [NodeW-1:0] dst;
    bit [CostW-1:0] cost;
    bit             last;
    bit             dropped;
  } tree_result_t;

  typedef struct {
    bit [NodeW-1:0] src;
    bit [NodeW-1:0] dst;
    bit [CostW-1:0] cost;
  } stored_edge_t;

  class mst_scoreboard;
    tree_result_t   pending[$];
    int unsigned    errors;
    stored_edge_t   graph[$];
    bit             drop_seen;
    bit [CountW-1:0] node_count;
    bit [NodeW-1:0] parent[MaxNodes];
    bit [RankW-1:0] rank_of[MaxNodes];

    function new();
      node_count = NodeCountReset;
    endfunction

    function bit [NodeW-1:0] root_of(bit [NodeW-1:0] v);
      bit [NodeW-1:0] r;
      bit [NodeW-1:0] w;
      bit [NodeW-1:0] nxt;
      r = v;
      while (parent[r] != r) r = parent[r];
      w = v;
      while (w != r) begin
        nxt = parent[w];
        parent[w] = r;
        w = nxt;
      end
      return r;
    endfunction

    function void note_edge(bit [NodeW-1:0] s, bit [NodeW-1:0] d,
                            bit [CostW-1:0] c, bit is_last);
      int unsigned  lim;
      stored_edge_t sorted[$];
      stored_edge_t key;
      stored_edge_t ne;
      tree_result_t res;
      int           j;
      int unsigned  emitted;
      bit [NodeW-1:0] ra, rb;
      lim = (node_count < MaxNodes) ? node_count : MaxNodes;
      if (s >= lim || d >= lim || graph.size() >= MaxEdges) drop_seen = 1;
      else begin
        ne = '{s, d, c};
        graph.insert(graph.size(), ne);
      end
      if (!is_last) return;
      // stable insertion sort by cost
      sorted = graph;
      for (int i = 1; i < sorted.size(); i++) begin
        key = sorted[i];
        j = i;
        while (j > 0 && sorted[j-1].cost > key.cost) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = key;
      end
      for (int i = 0; i < MaxNodes; i++) begin
        parent[i] = NodeW'(i);
        rank_of[i] = '0;
      end
      emitted = 0;
      foreach (sorted[i]) begin
        if (emitted >= MaxNodes - 1) break;
        ra = root_of(sorted[i].src);
        rb = root_of(sorted[i].dst);
        if (ra == rb) continue;
        if (rank_of[ra] < rank_of[rb]) parent[ra] = rb;
        else begin
          parent[rb] = ra;
          if (rank_of[ra] == rank_of[rb]) rank_of[ra] = RankW'(rank_of[ra] + 1);
        end
        res = '{1'b1, sorted[i].src, sorted[i].dst, sorted[i].cost, 1'b0, 1'b0};
        pending.insert(pending.size(), res);
        emitted++;
      end
      res = '{1'b0, '0, '0, '0, 1'b1, drop_seen};
      pending.insert(pending.size(), res);
      graph.delete();
      drop_seen = 0;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(tree_result_t got);
      tree_result_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      exp = pending.pop_front();
      if (got.is_edge != exp.is_edge || got.src != exp.src || got.dst != exp.dst ||
          got.cost != exp.cost || got.last != exp.last || got.dropped != exp.dropped)
        report($sformatf("got %p expected %p", got, exp));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [NodeW-1:0]    edge_src_i = '0;
  logic [NodeW-1:0]    edge_dst_i = '0;
  logic [CostW-1:0]    edge_cost_i = '0;
  logic                edge_is_last_i = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CountW-1:0]   cfg_wdata_i = '0;
  logic                result_valid_o;
  logic                out_valid_edge_o;
  logic [NodeW-1:0]    out_src_o;
  logic [NodeW-1:0]    out_dst_o;
  logic [CostW-1:0]    out_cost_o;
  logic                out_last_o;
  logic                out_dropped_o;

  mst_scoreboard sb = new();
  int unsigned   cycles;
  int unsigned   items_sent;

  always #4 clk_i = ~clk_i;

  minimum_spanning_tree_kruskal_unit #(
    .MaxNodes(MaxNodes),
    .MaxEdges(MaxEdges)
  ) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .edge_src_i(edge_src_i), .edge_dst_i(edge_dst_i), .edge_cost_i(edge_cost_i),
    .edge_is_last_i(edge_is_last_i), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .result_valid_o(result_valid_o), .out_valid_edge_o(out_valid_edge_o),
    .out_src_o(out_src_o), .out_dst_o(out_dst_o), .out_cost_o(out_cost_o),
    .out_last_o(out_last_o), .out_dropped_o(out_dropped_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_result('{out_valid_edge_o, out_src_o, out_dst_o, out_cost_o,
                        out_last_o, out_dropped_o});
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk_i);
  endtask

  task send_edge(bit [NodeW-1:0] s, bit [NodeW-1:0] d, bit [CostW-1:0] c, bit is_last);
    bit taken;
    idle_gap();
    @(negedge clk_i);
    start <= 1'b1;
    edge_src_i <= s;
    edge_dst_i <= d;
    edge_cost_i <= c;
    edge_is_last_i <= is_last;
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
      if (!taken) @(negedge clk_i);
    end
    sb.note_edge(s, d, c, is_last);
    items_sent++;
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task wait_drained();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // waits until the unit has drained before writing
  task write_node_count(bit [CountW-1:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.node_count = v;
  endtask

  task random_graph(int unsigned n);
    int unsigned lim;
    bit          ties;
    bit [CostW-1:0] c;
    lim = (sb.node_count == 0) ? 1 : ((sb.node_count < MaxNodes) ? sb.node_count : MaxNodes);
    ties = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      c = ties ? CostW'($urandom_range(0, 3)) : CostW'($urandom());
      if ($urandom_range(0, 9) == 0)
        send_edge(NodeW'($urandom()), NodeW'($urandom()), c, i == n - 1);
      else
        send_edge(NodeW'($urandom_range(0, lim - 1)), NodeW'($urandom_range(0, lim - 1)),
                  c, i == n - 1);
    end
  endtask

  initial begin
    int unsigned graphs;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, self loop, tie order, all at reset node count
    send_edge(6'd63, 6'd0, 16'hFFFF, 1'b0);
    send_edge(6'd0, 6'd0, 16'h0000, 1'b0);
    send_edge(6'd1, 6'd2, 16'h0005, 1'b0);
    send_edge(6'd2, 6'd3, 16'h0005, 1'b0);
    send_edge(6'd1, 6'd3, 16'h0005, 1'b0);
    send_edge(6'd62, 6'd63, 16'h0000, 1'b1);
    // single edge graph
    send_edge(6'd42, 6'd21, 16'hAAAA, 1'b1);
    // vertex out of range
    write_node_count(7'd5);
    send_edge(6'd4, 6'd0, 16'h0003, 1'b0);
    send_edge(6'd5, 6'd1, 16'h0001, 1'b0);
    send_edge(6'd3, 6'd4, 16'h0002, 1'b1);
    // everything dropped at node count 0, some at 1, none at 127
    write_node_count(7'd0);
    send_edge(6'd0, 6'd0, 16'h1234, 1'b1);
    write_node_count(7'd1);
    send_edge(6'd0, 6'd0, 16'h5555, 1'b0);
    send_edge(6'd0, 6'd1, 16'h5555, 1'b1);
    write_node_count(7'd127);
    send_edge(6'd63, 6'd62, 16'h8000, 1'b0);
    send_edge(6'd21, 6'd42, 16'h7FFF, 1'b1);
    wait_drained();   // sender holds off until all results are in

    // small graphs first, leaving room for one graph that overflows the store
    graphs = 0;
    while (items_sent + BigGraph < ItemTarget + 24) begin
      if (graphs % 2 == 1) begin
        case ($urandom_range(0, 4))
          0: write_node_count(7'd64);
          1: write_node_count(7'd127);
          2: write_node_count(CountW'($urandom_range(2, 8)));
          3: write_node_count(CountW'($urandom()));
          default: write_node_count(CountW'($urandom_range(1, 64)));
        endcase
      end
      random_graph($urandom_range(1, 12));
      graphs++;
    end

    write_node_count(7'd64);
    random_graph(BigGraph);

    wait_drained();
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
